@@ hdl/sfir_pkg.sv @@
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants and types for the stereo symmetric FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfir_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int CFG_W        = 64;
  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_W    = 3;
  localparam int COEFS_PER_SET = 16;
  localparam int TAPS_DEF     = 19;

  // Register indices of the first register of each coefficient set
  localparam logic [REG_IDX_W-1:0] REG_LOWPASS_A  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGHPASS_A = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sfir_state_e;

endpackage : sfir_pkg

`default_nettype wire

@@ hdl/sfir_in_if.sv @@
// ----------------------------------------------------------------------------
// sfir_in_if
// Input stream channel: one stereo sample pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfir_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface : sfir_in_if

`default_nettype wire

@@ hdl/sfir_out_if.sv @@
// ----------------------------------------------------------------------------
// sfir_out_if
// Output stream channel: one filtered stereo pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfir_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface : sfir_out_if

`default_nettype wire

@@ hdl/sfir_cell.sv @@
// ----------------------------------------------------------------------------
// sfir_cell
// One tap-pair cell: pre-add, multiply, add onto the neighbour's partial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_cell
  import sfir_pkg::*;
#(
  parameter int AccW = 37
) (
  input  wire                        clk_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_a_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_b_i,
  input  wire logic signed [COEF_W-1:0]   coef_i,
  input  wire logic signed [AccW-1:0]     sum_i,
  output logic signed [AccW-1:0]          sum_o
);

  localparam int PreW  = SAMPLE_W + 1;
  localparam int ProdW = PreW + COEF_W;

  logic signed [PreW-1:0]  pre_d,  pre_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  sum_d,  sum_q;

  assign pre_d  = {sample_a_i[SAMPLE_W-1], sample_a_i} + {sample_b_i[SAMPLE_W-1], sample_b_i};
  assign prod_d = pre_q * coef_i;
  assign sum_d  = sum_i + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    pre_q  <= pre_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule : sfir_cell

`default_nettype wire

@@ hdl/stereo_symmetric_fir_filter_top.sv @@
// ----------------------------------------------------------------------------
// stereo_symmetric_fir_filter_top
// Stereo Type I symmetric FIR: low-pass on left, high-pass on right.
// ----------------------------------------------------------------------------
// Path: an accepted beat enters the delay lines, then passes each cell's pre-add,
//   product and sum registers while the partial sum walks through the chain of
//   H+1 tap-pair cells, H = (TAPS-1)/2, and is then loaded into the output register.
// One stereo pair is in flight: no new pair is taken until its result is loaded.
// Reset: asynchronous, active low; clears delay lines, coefficients, control.
`default_nettype none

module stereo_symmetric_fir_filter_top
  import sfir_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  sfir_in_if.sink                     in_i,
  sfir_out_if.source                  out_o,
  input  wire                         cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i
);

  // Half length; cell HALF carries the centre tap
  localparam int HALF  = (TAPS - 1) / 2;
  localparam int NCELL = HALF + 1;
  localparam int ProdW = SAMPLE_W + 1 + COEF_W;
  localparam int AccW  = ProdW + $clog2(NCELL);
  localparam int CntW  = $clog2(HALF + 4);
  localparam int SetW  = CFG_W * (NUM_REGS / 2);
  localparam int FracW = COEF_W - 1;

  // --------------------------------------------------------------------------
  // Coefficient registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] coef_q [NUM_REGS];
  logic [SetW-1:0]  lp_set, hp_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) coef_q[r] <= '0;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Flatten each set so coefficient k sits at bits k*16 upward
  assign lp_set = {coef_q[REG_LOWPASS_A + 3'd3], coef_q[REG_LOWPASS_A + 3'd2],
                   coef_q[REG_LOWPASS_A + 3'd1], coef_q[REG_LOWPASS_A]};
  assign hp_set = {coef_q[REG_HIGHPASS_A + 3'd3], coef_q[REG_HIGHPASS_A + 3'd2],
                   coef_q[REG_HIGHPASS_A + 3'd1], coef_q[REG_HIGHPASS_A]};

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  sfir_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            load_out;
  logic            in_ready;

  assign accept = in_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_RUN;
      ST_RUN:  if (load_out)   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      // Drain the chain, then hand over once the output register is free
      ST_RUN:  load_out = (cnt_q == '0) && (!out_o.valid || out_o.ready);
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = CntW'(HALF + 3);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_i.ready = in_ready;

  // --------------------------------------------------------------------------
  // Delay lines: advance by one sample on each accepted beat, newest at 0
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] lhist_q [TAPS];
  logic signed [SAMPLE_W-1:0] rhist_q [TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        lhist_q[i] <= '0;
        rhist_q[i] <= '0;
      end
    end else if (accept) begin
      lhist_q[0] <= in_i.left_in;
      rhist_q[0] <= in_i.right_in;
      for (int i = 1; i < TAPS; i++) begin
        lhist_q[i] <= lhist_q[i-1];
        rhist_q[i] <= rhist_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell chains: cell k pre-adds tap k with its mirror, the centre cell takes
  // its tap alone; partial sums hand forward from cell 0 to cell HALF
  // --------------------------------------------------------------------------
  logic signed [AccW-1:0] lsum [NCELL];
  logic signed [AccW-1:0] rsum [NCELL];

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] lb, rb;
    logic signed [AccW-1:0]     lin, rin;

    if (k == HALF) begin : g_centre
      assign lb = '0;
      assign rb = '0;
    end else begin : g_pair
      assign lb = lhist_q[TAPS-1-k];
      assign rb = rhist_q[TAPS-1-k];
    end

    if (k == 0) begin : g_head
      assign lin = '0;
      assign rin = '0;
    end else begin : g_link
      assign lin = lsum[k-1];
      assign rin = rsum[k-1];
    end

    sfir_cell #(.AccW(AccW)) u_lcell (
      .clk_i      (clk_i),
      .sample_a_i (lhist_q[k]),
      .sample_b_i (lb),
      .coef_i     (lp_set[k*COEF_W +: COEF_W]),
      .sum_i      (lin),
      .sum_o      (lsum[k])
    );

    sfir_cell #(.AccW(AccW)) u_rcell (
      .clk_i      (clk_i),
      .sample_a_i (rhist_q[k]),
      .sample_b_i (rb),
      .coef_i     (hp_set[k*COEF_W +: COEF_W]),
      .sum_i      (rin),
      .sum_o      (rsum[k])
    );
  end

  // --------------------------------------------------------------------------
  // Scale: drop the Q15 fraction rounding toward zero, then clamp to 16 bits
  // --------------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] scale_sat(logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] biased;
    logic signed [AccW-1:0] q;
    logic signed [AccW-1:0] hi_lim;
    logic signed [AccW-1:0] lo_lim;
    hi_lim = AccW'((1 << (SAMPLE_W - 1)) - 1);
    lo_lim = -hi_lim - 1'b1;
    biased = acc[AccW-1] ? acc + AccW'((1 << FracW) - 1) : acc;
    q      = biased >>> FracW;
    priority if (q > hi_lim) scale_sat = hi_lim[SAMPLE_W-1:0];
    else if (q < lo_lim)     scale_sat = lo_lim[SAMPLE_W-1:0];
    else                     scale_sat = q[SAMPLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Output register: hold the result until the sink takes the beat
  // --------------------------------------------------------------------------
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      left_out_q  <= scale_sat(lsum[HALF]);
      right_out_q <= scale_sat(rsum[HALF]);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = left_out_q;
  assign out_o.right_out = right_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // One pair in flight: no further beat straight after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a pair is still in the chain");

  // Handing over a result frees the block and shows the beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_o.valid && state_q == ST_IDLE))
    else $error("result load did not raise valid or release the block");

  // Drain counter is always spent when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("drain counter running while idle");

endmodule : stereo_symmetric_fir_filter_top

`default_nettype wire
